/* design/sfcc_pkg.sv */
// shared types, constants and the crc step for the sensor frame crc checker
`timescale 1ns / 1ps
`default_nettype none

package sfcc_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int CNT_W       = 3;
    localparam int HELD_BYTES  = 4;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] NOT_READY_MASK = 8'h01;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NOT_READY = 2'd1;
    localparam logic [1:0] ERR_CRC       = 2'd2;
    localparam logic [1:0] ERR_BUS       = 2'd3;

    localparam logic [1:0] KIND_PPM = 2'd0;
    localparam logic [1:0] KIND_CAL = 2'd1;
    localparam logic [1:0] KIND_VER = 2'd2;
    localparam logic [1:0] KIND_RES = 2'd3;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [27:0] main_value;
        logic [7:0]  status_byte;
        logic [15:0] cal_status;
        logic [15:0] cal_word;
        logic        cal_valid;
        logic [1:0]  answered_kind;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic             last_byte;
    } t_frame_status;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/sfcc_frame.sv */
// frame state, crc update and reply decode for one received byte
`timescale 1ns / 1ps
`default_nettype none

module sfcc_frame
    import sfcc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [1:0]    i_reg_kind,
    input  wire logic          i_bus_fail,
    output logic               o_emit,
    output t_result            o_result,
    output t_frame_status      o_status
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_crc, n_crc;
    logic [23:0]      r_last_ppm, n_last_ppm;
    logic [7:0]       r_held [HELD_BYTES];
    logic [7:0]       w_h    [HELD_BYTES];

    logic [7:0]  w_crc;
    logic        w_last;
    logic        w_crc_ok;
    logic [23:0] w_ppm;
    logic [23:0] w_raw;
    t_result     w_res;

    assign w_crc    = crc8_step(r_crc, i_rx_byte);
    assign w_last   = ({1'b0, r_count} + 4'd1) >= 4'(FRAME_BYTES);
    assign w_crc_ok = (w_crc == 8'h00);
    assign o_emit   = i_bus_fail || w_last;

    // current byte shows through to the decode in the cycle it is written
    always_comb begin
        for (int i = 0; i < HELD_BYTES; i++) begin
            if (!i_bus_fail && r_count == CNT_W'(i)) begin
                w_h[i] = i_rx_byte;
            end else begin
                w_h[i] = r_held[i];
            end
        end
    end

    assign w_ppm = {w_h[1], w_h[2], w_h[3]};
    assign w_raw = {w_h[0], w_h[1], w_h[2]};

    always_comb begin
        w_res = '0;
        w_res.answered_kind = i_reg_kind;
        n_last_ppm = r_last_ppm;
        if (i_bus_fail) begin
            w_res.error_code = ERR_BUS;
            if (i_reg_kind == KIND_PPM) begin
                w_res.main_value = {4'd0, r_last_ppm};
            end else if (i_reg_kind == KIND_VER) begin
                w_res.main_value = 28'hFF;
            end
        end else begin
            w_res.status_byte = w_h[0];
            case (i_reg_kind)
                KIND_PPM: begin
                    if (!w_crc_ok) begin
                        w_res.error_code = ERR_CRC;
                        w_res.main_value = {4'd0, r_last_ppm};
                    end else if ((w_h[0] & NOT_READY_MASK) != 8'h00) begin
                        w_res.error_code = ERR_NOT_READY;
                        w_res.main_value = {4'd0, r_last_ppm};
                    end else begin
                        w_res.main_value = {4'd0, w_ppm};
                        n_last_ppm = w_ppm;
                    end
                end
                KIND_CAL: begin
                    if (w_crc_ok) begin
                        w_res.cal_status = {w_h[0], w_h[1]};
                        w_res.cal_word   = {w_h[2], w_h[3]};
                        w_res.cal_valid  = 1'b1;
                    end else begin
                        w_res.error_code = ERR_CRC;
                    end
                end
                KIND_VER: begin
                    w_res.main_value = {20'd0, w_h[3]};
                    if (!w_crc_ok) begin
                        w_res.error_code = ERR_CRC;
                    end
                end
                default: begin
                    // times ten as eight plus two
                    w_res.main_value = {1'b0, w_raw, 3'd0} + {3'd0, w_raw, 1'b0};
                    if (!w_crc_ok) begin
                        w_res.error_code = ERR_CRC;
                    end
                end
            endcase
        end
    end

    assign o_result = w_res;
    assign o_status = '{byte_count: r_count, last_byte: w_last};

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (i_bus_fail || w_last) begin
            n_count = '0;
            n_crc   = CRC_INIT;
        end else begin
            n_count = r_count + CNT_W'(1);
            n_crc   = w_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_last_ppm <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            if (!i_bus_fail && w_last) begin
                r_last_ppm <= n_last_ppm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && !i_bus_fail) begin
            for (int i = 0; i < HELD_BYTES; i++) begin
                if (r_count == CNT_W'(i)) begin
                    r_held[i] <= i_rx_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/sensor_frame_crc_checker.sv */
// Sensor reply checker: takes one reply byte per item, runs a CRC-8 (poly 0x31, init 0xFF)
// over each five-byte frame and reports the decoded reply after the last byte or at once on
// a bus failure. A new byte can be taken every cycle unless a frame-ending byte is held
// back; each item passes through the input register, the crc step and decode run in a
// single pass, and the result is held in an output register. Bytes that end no frame do
// not wait for the output register; a stalled result only holds back the next frame-ending
// byte.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_crc_checker
    import sfcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [1:0]  i_reg_kind,
    input  wire logic        i_bus_fail,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_error_code,
    output logic [27:0]      o_main_value,
    output logic [7:0]       o_status_byte,
    output logic [15:0]      o_cal_status,
    output logic [15:0]      o_cal_word,
    output logic             o_cal_valid,
    output logic [1:0]       o_answered_kind
);

    logic        r_in_valid;
    logic [7:0]  r_in_rx;
    logic [1:0]  r_in_kind;
    logic        r_in_fail;
    logic        r_out_valid;
    t_result     r_out;

    logic          w_emit;
    logic          w_adv;
    logic          w_in_acc;
    logic          w_out_take;
    t_result       w_result;
    t_frame_status w_status;

    sfcc_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_adv),
        .i_rx_byte  (r_in_rx),
        .i_reg_kind (r_in_kind),
        .i_bus_fail (r_in_fail),
        .o_emit     (w_emit),
        .o_result   (w_result),
        .o_status   (w_status)
    );

    assign w_out_take = r_out_valid && !i_stall;
    assign w_adv      = r_in_valid && (!w_emit || !r_out_valid || !i_stall);
    assign o_stall    = r_in_valid && !w_adv;
    assign w_in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_rx   <= i_rx_byte;
            r_in_kind <= i_reg_kind;
            r_in_fail <= i_bus_fail;
        end
        if (w_adv && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_error_code    = r_out.error_code;
    assign o_main_value    = r_out.main_value;
    assign o_status_byte   = r_out.status_byte;
    assign o_cal_status    = r_out.cal_status;
    assign o_cal_word      = r_out.cal_word;
    assign o_cal_valid     = r_out.cal_valid;
    assign o_answered_kind = r_out.answered_kind;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_emit && r_out_valid && i_stall) |-> !w_adv)
        else $error("result register overwritten while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, w_status.byte_count} < 4'(FRAME_BYTES)))
        else $error("byte count past frame length");

    a_cal_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cal_valid) |->
        (o_answered_kind == KIND_CAL && o_error_code == ERR_OK))
        else $error("cal valid on a failed or non calibration reply");

    a_not_ready_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_NOT_READY) |-> (o_answered_kind == KIND_PPM))
        else $error("not ready reported for a non ppm reply");

endmodule

`default_nettype wire

/* sim/tb_sensor_frame_crc_checker.sv */
// testbench for sensor_frame_crc_checker: framed sensor replies under random flow control
`timescale 1ns / 1ps

module tb_sensor_frame_crc_checker;
    import sfcc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    class reply_scoreboard;
        t_result    expected_replies[$];
        int         errors;
        bit [2:0]   byte_cnt;
        bit [7:0]   crc_acc;
        bit [7:0]   held[HELD_BYTES];
        bit [23:0]  good_ppm;

        function new();
            errors   = 0;
            byte_cnt = '0;
            crc_acc  = CRC_INIT;
            good_ppm = '0;
            foreach (held[i]) held[i] = '0;
        endfunction

        static function bit [7:0] crc_update(bit [7:0] crc, bit [7:0] b);
            bit [7:0] c;
            bit       fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function void note_byte(bit [7:0] b, bit [1:0] kind, bit fail);
            t_result  r;
            bit [7:0] c;
            bit       crc_ok;
            r = '0;
            r.answered_kind = kind;
            if (fail) begin
                byte_cnt     = '0;
                crc_acc      = CRC_INIT;
                r.error_code = ERR_BUS;
                if (kind == KIND_PPM) r.main_value = 28'(good_ppm);
                else if (kind == KIND_VER) r.main_value = 28'hFF;
                expected_replies.push_back(r);
                return;
            end
            c = crc_update(crc_acc, b);
            if (byte_cnt < HELD_BYTES) held[byte_cnt] = b;
            if (int'(byte_cnt) + 1 < FRAME_BYTES) begin
                byte_cnt++;
                crc_acc = c;
                return;
            end
            byte_cnt      = '0;
            crc_acc       = CRC_INIT;
            crc_ok        = (c == 8'h00);
            r.status_byte = held[0];
            case (kind)
                KIND_PPM: begin
                    if (!crc_ok) r.error_code = ERR_CRC;
                    else if ((held[0] & NOT_READY_MASK) != 0) r.error_code = ERR_NOT_READY;
                    else good_ppm = {held[1], held[2], held[3]};
                    r.main_value = 28'(good_ppm);
                end
                KIND_CAL: begin
                    if (crc_ok) begin
                        r.cal_status = {held[0], held[1]};
                        r.cal_word   = {held[2], held[3]};
                        r.cal_valid  = 1'b1;
                    end else begin
                        r.error_code = ERR_CRC;
                    end
                end
                KIND_VER: begin
                    r.main_value = 28'(held[3]);
                    if (!crc_ok) r.error_code = ERR_CRC;
                end
                default: begin
                    r.main_value = 28'({held[0], held[1], held[2]}) * 28'd10;
                    if (!crc_ok) r.error_code = ERR_CRC;
                end
            endcase
            expected_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_replies.size() == 0) begin
                $error("reply with none pending: kind %0d error %0d",
                       got.answered_kind, got.error_code);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
            compare_field("main_value", 32'(want.main_value), 32'(got.main_value));
            compare_field("status_byte", 32'(want.status_byte), 32'(got.status_byte));
            compare_field("cal_status", 32'(want.cal_status), 32'(got.cal_status));
            compare_field("cal_word", 32'(want.cal_word), 32'(got.cal_word));
            compare_field("cal_valid", 32'(want.cal_valid), 32'(got.cal_valid));
            compare_field("answered_kind", 32'(want.answered_kind), 32'(got.answered_kind));
        endfunction

        function int pending_count();
            return expected_replies.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic [1:0]  i_reg_kind;
    logic        i_bus_fail;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_error_code;
    logic [27:0] o_main_value;
    logic [7:0]  o_status_byte;
    logic [15:0] o_cal_status;
    logic [15:0] o_cal_word;
    logic        o_cal_valid;
    logic [1:0]  o_answered_kind;

    reply_scoreboard sb;
    int items_sent;
    int idle_cycles;
    bit no_gaps;
    bit rx_quiet;
    bit hold_req;

    sensor_frame_crc_checker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_reg_kind      (i_reg_kind),
        .i_bus_fail      (i_bus_fail),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_error_code    (o_error_code),
        .o_main_value    (o_main_value),
        .o_status_byte   (o_status_byte),
        .o_cal_status    (o_cal_status),
        .o_cal_word      (o_cal_word),
        .o_cal_valid     (o_cal_valid),
        .o_answered_kind (o_answered_kind)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [31:0] rand_body();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit [1:0] kind, input bit fail);
        int gap;
        gap = no_gaps ? 0 : gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_rx_byte  <= b;
        i_reg_kind <= kind;
        i_bus_fail <= fail;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(b, kind, fail);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input bit [31:0] body, input bit [1:0] kind, input bit bad);
        bit [7:0] crc;
        bit [7:0] b;
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            b   = (i < HELD_BYTES) ? body[31 - 8 * i -: 8] : 8'($urandom);
            crc = reply_scoreboard::crc_update(crc, b);
            send_byte(b, 2'($urandom_range(0, 3)), 1'b0);
        end
        if (bad) crc ^= 8'($urandom_range(1, 255));
        send_byte(crc, kind, 1'b0);
    endtask

    task automatic send_abort(input bit [1:0] kind);
        int n;
        n = $urandom_range(0, FRAME_BYTES - 1);
        repeat (n) send_byte(8'($urandom), 2'($urandom_range(0, 3)), 1'b0);
        send_byte(8'($urandom), kind, 1'b1);
    endtask

    task automatic run_random(input int n);
        int target;
        int r;
        target = items_sent + n;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_frame(rand_body(), 2'($urandom_range(0, 3)), 1'b0);
            end else if (r < 85) begin
                send_frame(rand_body(), 2'($urandom_range(0, 3)), 1'b1);
            end else if (r < 93) begin
                send_abort(2'($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 7))
                    send_byte(8'($urandom), 2'($urandom_range(0, 3)),
                              $urandom_range(0, 9) == 0);
                send_abort(2'($urandom_range(0, 3)));
            end
        end
    endtask

    // receiver side flow control
    initial begin : receiver
        int run_left;
        bit stall_now;
        i_stall  = 1'b0;
        run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                stall_now = ($urandom_range(0, 2) == 0);
                run_left  = stall_now ? gap_length() : $urandom_range(0, 6);
                i_stall   <= stall_now;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_error_code, o_main_value, o_status_byte, o_cal_status,
                             o_cal_word, o_cal_valid, o_answered_kind});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_reg_kind  = '0;
        i_bus_fail  = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        rx_quiet    = 1'b0;
        hold_req    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_frame(32'h00FF_FFFF, KIND_PPM, 1'b0);
        send_frame(32'h0112_3456, KIND_PPM, 1'b0);
        send_frame(32'hFFFF_FF00, KIND_RES, 1'b0);
        send_frame(32'h80FF_00FE, KIND_CAL, 1'b1);
        send_frame(32'hFEDC_0123, KIND_CAL, 1'b0);
        send_frame(32'h0000_00AB, KIND_VER, 1'b0);
        send_byte(8'hFF, KIND_PPM, 1'b0);
        send_byte(8'h5A, KIND_PPM, 1'b1);
        send_byte(8'hFF, KIND_VER, 1'b1);

        run_random(400);

        // receiver holds off while items keep coming
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        run_random(150);
        no_gaps  = 1'b0;

        run_random(300);

        // sender waits for all replies to drain
        i_valid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge i_clk);

        run_random(300);

        no_gaps  = 1'b1;
        rx_quiet = 1'b1;
        run_random(200);
        no_gaps  = 1'b0;
        rx_quiet = 1'b0;

        run_random(250);

        i_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
